>>> rtl/refcounted_page_allocator_assert.svh
// Assertion macros shared by the page allocator RTL.
// Needs clk and rst in the scope where a macro is used.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define RPA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("page allocator invariant violated");
`define RPA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("page allocator sequence violated");
`else
`define RPA_ASSERT_ALWAYS(lbl, expr)
`define RPA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> rtl/rpa_pkg.sv
// Types and codes of the reference-counted page allocator.
// Used by rpa_outbuf, rpa_core and refcounted_page_allocator.
`default_nettype none

package rpa_pkg;

  localparam int ADDR_BITS = 28;

  // Request opcodes.
  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_INC   = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  // Result status codes.
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_OOM   = 3'd1;
  localparam logic [2:0] STAT_BAD   = 3'd2;
  localparam logic [2:0] STAT_UNDER = 3'd3;
  localparam logic [2:0] STAT_SAT   = 3'd4;

  // Register indexes.
  localparam int REG_LOW_PAGE = 0;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } rpa_state_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [ADDR_BITS-1:0] address;
  } rpa_req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] page_address;
    logic [15:0]          ref_count;
    logic                 released;
    logic [16:0]          free_count;
  } rpa_rsp_t;

endpackage

`default_nettype wire

>>> rtl/rpa_outbuf.sv
// Two-entry result buffer: the output register plus one holding slot.
// Depends on rpa_pkg for the result type.
`default_nettype none

`include "refcounted_page_allocator_assert.svh"

module rpa_outbuf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  rpa_pkg::rpa_rsp_t       push_data,
  output logic                    room,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rpa_pkg::rpa_rsp_t       rsp
);
  import rpa_pkg::*;

  logic      pend_valid;
  rpa_rsp_t  pend;
  logic      out_free;

  assign out_free = !rsp_valid || !rsp_stall;
  assign room     = !pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid  <= pend_valid || push;
      pend_valid <= 1'b0;
    end else if (push) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        rsp <= pend;
      end else if (push) begin
        rsp <= push_data;
      end
    end else if (push) begin
      pend <= push_data;
    end
  end

  // The holding slot is only used while the output register is full.
  `RPA_ASSERT_ALWAYS(a_pend_implies_out, !pend_valid || rsp_valid)
  `RPA_ASSERT_ALWAYS(a_no_push_when_full, !push || !pend_valid)

endmodule

`default_nettype wire

>>> rtl/rpa_core.sv
// Allocator engine: link and count memories, list head state and sequencer.
// Depends on rpa_pkg; results go to rpa_outbuf.
`default_nettype none

`include "refcounted_page_allocator_assert.svh"

module rpa_core #(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [15:0]        low_page,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  rpa_pkg::rpa_req_t       req,
  input  wire logic               room,
  output logic                    push,
  output rpa_pkg::rpa_rsp_t       res
);
  import rpa_pkg::*;

  localparam int PAGE_BITS  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [PAGE_BITS-1:0]  LAST_PAGE = PAGE_BITS'(PAGE_COUNT - 1);
  localparam logic [COUNT_BITS-1:0] MAX_COUNT = '1;

  // Memories.
  logic [PAGE_BITS-1:0]  link_mem [PAGE_COUNT];
  logic [COUNT_BITS-1:0] refs_mem [PAGE_COUNT];
  logic [PAGE_BITS-1:0]  link_rd;
  logic [COUNT_BITS-1:0] refs_rd;
  logic [PAGE_BITS-1:0]  rd_addr;
  logic                  link_we;
  logic [PAGE_BITS-1:0]  link_waddr;
  logic [PAGE_BITS-1:0]  link_wdata;
  logic                  refs_we;
  logic [PAGE_BITS-1:0]  refs_waddr;
  logic [COUNT_BITS-1:0] refs_wdata;

  // Control and list state.
  rpa_state_t            state;
  rpa_state_t            state_next;
  logic [PAGE_BITS-1:0]  idx;
  logic                  build;
  logic [PAGE_BITS-1:0]  list_head;
  logic [PAGE_BITS-1:0]  head_next;
  logic                  list_empty;
  logic                  empty_next;
  logic [16:0]           pages_free;
  logic [16:0]           pf_next;

  // Captured request.
  logic [2:0]            cur_op;
  logic [PAGE_BITS-1:0]  cur_pg;
  logic                  cur_ok;

  logic                  accept;
  logic [31:0]           req_page;
  logic                  req_ok;
  logic                  low_in_range;
  logic [31:0]           cnt_ext;
  logic [COUNT_BITS-1:0] refs_dec;
  logic [COUNT_BITS-1:0] refs_inc;

  assign req_stall = (state != S_IDLE) || !room;
  assign accept    = req_valid && !req_stall;

  assign req_page = 32'(req.address[ADDR_BITS-1:PAGE_SHIFT]);
  assign req_ok   = (req.address[PAGE_SHIFT-1:0] == '0) &&
                    (req_page >= 32'(low_page)) &&
                    (req_page < 32'(PAGE_COUNT));
  assign rd_addr  = (req.op == OP_ALLOC) ? list_head : req_page[PAGE_BITS-1:0];

  assign low_in_range = 32'(low_page) < 32'(PAGE_COUNT);
  assign refs_dec     = refs_rd - COUNT_BITS'(1);
  assign refs_inc     = refs_rd + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      link_rd <= link_mem[rd_addr];
      refs_rd <= refs_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (refs_we) begin
      refs_mem[refs_waddr] <= refs_wdata;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_SWEEP: begin
        if (idx == LAST_PAGE) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (req.op == OP_INIT) ? S_SWEEP : S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory writes, list updates and the result of each request.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_pg;
    link_wdata = '0;
    refs_we    = 1'b0;
    refs_waddr = cur_pg;
    refs_wdata = '0;
    head_next  = list_head;
    empty_next = list_empty;
    pf_next    = pages_free;
    push       = 1'b0;
    cnt_ext    = '0;
    res        = '0;

    case (state)
      S_SWEEP: begin
        // Every count is cleared; on init the managed pages are also chained
        // in ascending order so the highest page ends up at the head.
        refs_we    = 1'b1;
        refs_waddr = idx;
        if (build && (32'(idx) >= 32'(low_page))) begin
          link_we    = 1'b1;
          link_waddr = idx;
          link_wdata = (32'(idx) == 32'(low_page)) ? '0 : idx - PAGE_BITS'(1);
        end
        if (build && (idx == LAST_PAGE)) begin
          push       = 1'b1;
          head_next  = low_in_range ? LAST_PAGE : '0;
          empty_next = !low_in_range;
          pf_next    = low_in_range ? 17'(PAGE_COUNT) - 17'(low_page) : '0;
        end
      end
      S_EXEC: begin
        push = 1'b1;
        case (cur_op)
          OP_ALLOC: begin
            if (list_empty) begin
              res.status = STAT_OOM;
            end else begin
              head_next            = link_rd;
              pf_next              = pages_free - 17'd1;
              empty_next           = (pf_next == '0);
              refs_we              = 1'b1;
              refs_waddr           = list_head;
              refs_wdata           = COUNT_BITS'(1);
              cnt_ext              = 32'd1;
              res.page_address     = ADDR_BITS'(list_head) << PAGE_SHIFT;
            end
          end
          OP_FREE: begin
            if (!cur_ok) begin
              res.status = STAT_BAD;
            end else if (refs_rd == '0) begin
              res.status = STAT_UNDER;
            end else begin
              refs_we    = 1'b1;
              refs_wdata = refs_dec;
              cnt_ext    = 32'(refs_dec);
              if (refs_dec == '0) begin
                link_we      = 1'b1;
                link_wdata   = list_empty ? '0 : list_head;
                head_next    = cur_pg;
                empty_next   = 1'b0;
                pf_next      = pages_free + 17'd1;
                res.released = 1'b1;
              end
            end
          end
          OP_INC: begin
            // A page with no references is not in use and cannot gain one.
            if (!cur_ok || (refs_rd == '0)) begin
              res.status = STAT_BAD;
            end else if (refs_rd == MAX_COUNT) begin
              res.status = STAT_SAT;
              cnt_ext    = 32'(refs_rd);
            end else begin
              refs_we    = 1'b1;
              refs_wdata = refs_inc;
              cnt_ext    = 32'(refs_inc);
            end
          end
          OP_QUERY: begin
            if (!cur_ok) begin
              res.status = STAT_BAD;
            end else begin
              cnt_ext = 32'(refs_rd);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.ref_count  = cnt_ext[15:0];
    res.free_count = pf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      idx        <= '0;
      build      <= 1'b0;
      list_head  <= '0;
      list_empty <= 1'b1;
      pages_free <= '0;
    end else begin
      state      <= state_next;
      list_head  <= head_next;
      list_empty <= empty_next;
      pages_free <= pf_next;
      if (state == S_SWEEP) begin
        idx <= idx + PAGE_BITS'(1);
      end
      if (accept && (req.op == OP_INIT)) begin
        idx   <= '0;
        build <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op <= req.op;
      cur_pg <= req_page[PAGE_BITS-1:0];
      cur_ok <= req_ok;
    end
  end

  `RPA_ASSERT_ALWAYS(a_free_bound, pages_free <= 17'(PAGE_COUNT))
  `RPA_ASSERT_ALWAYS(a_empty_matches_count, list_empty == (pages_free == '0))
  `RPA_ASSERT_NEXT(a_release_grows_list, push && res.released, pages_free == $past(pages_free) + 17'd1)

endmodule

`default_nettype wire

>>> rtl/refcounted_page_allocator.sv
// Top level of the reference-counted page allocator: register port and wiring.
// Depends on rpa_pkg, rpa_core and rpa_outbuf.
//
//   Channel   Signals                               Direction
//   req       req_valid, req_stall, req             request in, stall out
//   rsp       rsp_valid, rsp_stall, rsp             result out, stall in
//   config    psel, penable, pwrite, paddr, pwdata  register write and read
//
// Alloc, free, increment, query and unused ops read the count and link
// memories at the transfer and do any write-back in the following cycle.
// After its transfer, init sweeps the memories, one memory entry per cycle.
// After reset a clearing pass zeroes every count; no request is taken until
// it ends. Results sit in a two-entry buffer, so a stalled result does not
// block the next request.
`default_nettype none

module refcounted_page_allocator #(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  rpa_pkg::rpa_req_t       req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rpa_pkg::rpa_rsp_t       rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import rpa_pkg::*;

  localparam logic [1:0] ADDR_LOW_PAGE = 2'(4 * REG_LOW_PAGE);

  logic [15:0] low_page;
  logic        room;
  logic        push;
  rpa_rsp_t    res;

  assign pready = 1'b1;

  // Byte offsets within the word are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_page <= 16'd256;
    end else if (psel && penable && pwrite && pready &&
                 ((paddr & 2'b00) == ADDR_LOW_PAGE)) begin
      low_page <= pwdata[15:0];
    end
  end

  assign prdata = {16'd0, low_page};

  rpa_core #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .low_page  (low_page),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .room      (room),
    .push      (push),
    .res       (res)
  );

  rpa_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the refcounted page allocator: a directed table
// and randomized phases, checked against typed results or a local predictor.
// Depends on rpa_pkg and refcounted_page_allocator.
module tb;
  import rpa_pkg::*;

  localparam int PAGE_COUNT = 65536;
  localparam int PAGE_SHIFT = 12;
  localparam logic [15:0] RESET_LOW_PAGE = 16'd256;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [16:0] FREE_AFTER_INIT = 17'(PAGE_COUNT - RESET_LOW_PAGE);
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  rpa_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rpa_rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  refcounted_page_allocator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted allocator state.
  logic [15:0] link_mem [0:PAGE_COUNT-1];
  logic [15:0] ref_mem [0:PAGE_COUNT-1];
  logic [15:0] head_page = '0;
  bit list_is_empty = 1'b1;
  logic [16:0] pages_on_list = '0;
  logic [15:0] low_pg = RESET_LOW_PAGE;

  rpa_rsp_t pending_results[$];
  logic [15:0] pages_in_use[$];
  bit init_in_flight = 1'b0;
  int err_count = 0;
  int unsigned cycles = 0;

  // Receiver state: stall patterns that change every so often, plus a long hold-off.
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int unsigned hold_left = 0;
  logic [1:0] stall_mode = '0;
  int unsigned mode_left = 0;

  typedef struct {
    rpa_req_t req;
    bit typed;
    rpa_rsp_t want;
  } stim_row_t;
  stim_row_t stim_rows[$];

  initial begin
    for (int i = 0; i < PAGE_COUNT; i++) begin
      ref_mem[i] = '0;
      link_mem[i] = '0;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("MISMATCH %s: got %h, expected %h, cycle %0d", what, got, want, cycles);
  endtask

  function automatic void push_free(input logic [15:0] pg);
    link_mem[pg] = list_is_empty ? 16'h0 : head_page;
    head_page = pg;
    list_is_empty = 1'b0;
    pages_on_list = pages_on_list + 17'd1;
  endfunction

  function automatic rpa_rsp_t predict_page_op(input rpa_req_t r);
    rpa_rsp_t o;
    logic [15:0] pg;
    bit addr_ok;
    o = '0;
    pg = r.address[ADDR_BITS-1:PAGE_SHIFT];
    addr_ok = (r.address[PAGE_SHIFT-1:0] == '0) && (pg >= low_pg);
    case (r.op)
      OP_INIT: begin
        for (int i = 0; i < PAGE_COUNT; i++) ref_mem[i] = '0;
        head_page = '0;
        list_is_empty = 1'b1;
        pages_on_list = '0;
        for (int i = low_pg; i < PAGE_COUNT; i++) push_free(16'(i));
      end
      OP_ALLOC: begin
        if (list_is_empty) begin
          o.status = STAT_OOM;
        end else begin
          pg = head_page;
          head_page = link_mem[pg];
          pages_on_list = pages_on_list - 17'd1;
          if (pages_on_list == '0) list_is_empty = 1'b1;
          ref_mem[pg] = 16'd1;
          o.ref_count = 16'd1;
          o.page_address = {pg, 12'h000};
        end
      end
      OP_FREE: begin
        if (!addr_ok) begin
          o.status = STAT_BAD;
        end else if (ref_mem[pg] == '0) begin
          o.status = STAT_UNDER;
        end else begin
          ref_mem[pg] = ref_mem[pg] - 16'd1;
          o.ref_count = ref_mem[pg];
          if (ref_mem[pg] == '0) begin
            push_free(pg);
            o.released = 1'b1;
          end
        end
      end
      OP_INC: begin
        if (!addr_ok || ref_mem[pg] == '0) begin
          o.status = STAT_BAD;
        end else if (ref_mem[pg] == COUNT_MAX) begin
          o.status = STAT_SAT;
          o.ref_count = ref_mem[pg];
        end else begin
          ref_mem[pg] = ref_mem[pg] + 16'd1;
          o.ref_count = ref_mem[pg];
        end
      end
      OP_QUERY: begin
        if (!addr_ok) o.status = STAT_BAD;
        else o.ref_count = ref_mem[pg];
      end
      default: ;
    endcase
    o.free_count = pages_on_list;
    return o;
  endfunction

  // Keeps the list of pages that currently hold references, for stimulus.
  function automatic void track_pages(input rpa_req_t r, input rpa_rsp_t o);
    init_in_flight = (r.op == OP_INIT);
    if (r.op == OP_INIT) begin
      pages_in_use.delete();
    end else if (r.op == OP_ALLOC && o.status == STAT_OK) begin
      pages_in_use.push_back(o.page_address[ADDR_BITS-1:PAGE_SHIFT]);
    end else if (r.op == OP_FREE && o.released) begin
      for (int i = 0; i < pages_in_use.size(); i++) begin
        if (pages_in_use[i] == r.address[ADDR_BITS-1:PAGE_SHIFT]) begin
          pages_in_use.delete(i);
          break;
        end
      end
    end
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send(input rpa_req_t r, input bit typed = 1'b0,
                      input rpa_rsp_t typed_rsp = '0);
    rpa_rsp_t want;
    req <= r;
    req_valid <= 1'b1;
    do @(negedge clk); while (req_stall);
    @(posedge clk);
    want = predict_page_op(r);
    track_pages(r, want);
    pending_results.push_back(typed ? typed_rsp : want);
  endtask

  task automatic add_row(input logic [2:0] op, input logic [27:0] addr,
                         input bit typed = 1'b0, input logic [2:0] st = STAT_OK,
                         input logic [27:0] pa = '0, input logic [15:0] rc = '0,
                         input logic rl = 1'b0, input logic [16:0] fc = '0);
    stim_row_t row;
    row.req.op = op;
    row.req.address = addr;
    row.typed = typed;
    row.want.status = st;
    row.want.page_address = pa;
    row.want.ref_count = rc;
    row.want.released = rl;
    row.want.free_count = fc;
    stim_rows.push_back(row);
  endtask

  // Waits for every result, then for the sweep of a trailing init to end.
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (init_in_flight ? PAGE_COUNT + 16 : 16) @(posedge clk);
    init_in_flight = 1'b0;
  endtask

  task automatic read_low_page(output logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 2'(4 * REG_LOW_PAGE);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    value = prdata[15:0];
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_low_page(input logic [15:0] value);
    logic [15:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(4 * REG_LOW_PAGE);
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    low_pg = value;
    @(posedge clk);
    read_low_page(readback);
    if (readback !== value)
      report_mismatch("low_page readback", 32'(readback), 32'(value));
  endtask

  function automatic rpa_req_t pick_request();
    rpa_req_t r;
    int unsigned dice;
    logic [2:0] addr_op;
    dice = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: addr_op = OP_FREE;
      1: addr_op = OP_INC;
      default: addr_op = OP_QUERY;
    endcase
    r.op = addr_op;
    r.address = 28'($urandom);
    if (dice < 30) begin
      r.op = OP_ALLOC;
    end else if (dice < 70 && pages_in_use.size() != 0) begin
      r.op = (dice < 55) ? OP_FREE : (dice < 65) ? OP_INC : OP_QUERY;
      r.address = {pages_in_use[$urandom_range(0, pages_in_use.size() - 1)], 12'h000};
    end else if (dice < 84) begin
      // Managed page that may well be on the list: underflow and zero counts.
      r.address = {16'($urandom_range(low_pg, PAGE_COUNT - 1)), 12'h000};
    end else if (dice < 88) begin
      r.address = {16'($urandom), 12'($urandom_range(1, 4095))};
    end else if (dice < 92 && low_pg != 0) begin
      r.address = {16'($urandom_range(0, low_pg - 1)), 12'h000};
    end else if (dice >= 96) begin
      r.op = 3'(OP_RSVD_5 + $urandom_range(0, 2));
    end
    return r;
  endfunction

  task automatic run_random(input int count, input bit hold_off, input bit pause);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      if (hold_off && k == count / 3) begin
        // The receiver stops for a long stretch while items keep coming.
        hold_req <= ~hold_req;
        burst_left = 60;
      end
      if (pause && k == (2 * count) / 3) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      send(pick_request());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        2'd0: rsp_stall <= 1'b0;
        2'd1: rsp_stall <= ($urandom_range(0, 9) < 3);
        2'd2: rsp_stall <= ($urandom_range(0, 9) < 7);
        default: rsp_stall <= (cycles % 3) != 0;
      endcase
    end
  end

  // Inputs and outputs are stable from the falling edge to the next rising
  // edge, so a result seen here is the transfer at that rising edge.
  always @(negedge clk) begin : check_results
    rpa_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", 32'(rsp.status), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.page_address !== want.page_address)
          report_mismatch("page_address", 32'(rsp.page_address), 32'(want.page_address));
        if (rsp.ref_count !== want.ref_count)
          report_mismatch("ref_count", 32'(rsp.ref_count), 32'(want.ref_count));
        if (rsp.released !== want.released)
          report_mismatch("released", 32'(rsp.released), 32'(want.released));
        if (rsp.free_count !== want.free_count)
          report_mismatch("free_count", 32'(rsp.free_count), 32'(want.free_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] reg_value;
    rpa_req_t r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_low_page(reg_value);
    if (reg_value !== RESET_LOW_PAGE)
      report_mismatch("low_page after reset", 32'(reg_value), 32'(RESET_LOW_PAGE));

    // Before the first init only requests that touch no page count are sent.
    add_row(OP_ALLOC, 28'h0000000, 1, STAT_OOM);
    add_row(OP_QUERY, 28'h0000001, 1, STAT_BAD);
    add_row(OP_FREE, 28'h0000000, 1, STAT_BAD);
    add_row(OP_INC, 28'h0100800, 1, STAT_BAD);
    add_row(OP_RSVD_7, 28'hFFFFFFF, 1, STAT_OK);
    add_row(OP_INIT, 28'h0000000, 1, STAT_OK, 28'h0, 16'h0, 1'b0, FREE_AFTER_INIT);
    add_row(OP_ALLOC, 28'h0000000, 1, STAT_OK, 28'hFFFF000, 16'd1, 1'b0,
            FREE_AFTER_INIT - 17'd1);
    add_row(OP_ALLOC, 28'h0000000, 1, STAT_OK, 28'hFFFE000, 16'd1, 1'b0,
            FREE_AFTER_INIT - 17'd2);
    add_row(OP_INC, 28'hFFFF000, 1, STAT_OK, 28'h0, 16'd2, 1'b0, FREE_AFTER_INIT - 17'd2);
    add_row(OP_QUERY, 28'hFFFF000);
    add_row(OP_FREE, 28'hFFFF000);
    add_row(OP_FREE, 28'hFFFF000);
    add_row(OP_FREE, 28'hFFFF000, 1, STAT_UNDER, 28'h0, 16'h0, 1'b0,
            FREE_AFTER_INIT - 17'd1);
    add_row(OP_INC, 28'hFFFF000, 1, STAT_BAD, 28'h0, 16'h0, 1'b0, FREE_AFTER_INIT - 17'd1);
    add_row(OP_ALLOC, 28'h0000000);
    add_row(OP_QUERY, 28'h0100000);
    add_row(OP_QUERY, 28'h00FF000);
    add_row(OP_INC, 28'hFFFFFFF);
    add_row(OP_RSVD_5, 28'h0000000);
    add_row(OP_RSVD_6, 28'h5555555);
    add_row(OP_FREE, 28'hFFFE800);
    add_row(OP_INIT, 28'h0000000, 1, STAT_OK, 28'h0, 16'h0, 1'b0, FREE_AFTER_INIT);
    add_row(OP_QUERY, 28'hFFFE000);
    add_row(OP_ALLOC, 28'h0000000, 1, STAT_OK, 28'hFFFF000, 16'd1, 1'b0,
            FREE_AFTER_INIT - 17'd1);
    foreach (stim_rows[i]) send(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
    settle();

    // Largest list: every page managed.
    write_low_page(16'h0000);
    r.op = OP_INIT;
    r.address = '0;
    send(r);
    run_random(250, 1'b0, 1'b0);
    settle();

    // A single managed page.
    write_low_page(16'hFFFF);
    send(r);
    run_random(150, 1'b0, 1'b0);
    settle();

    write_low_page(16'd65520);
    send(r);
    run_random(450, 1'b1, 1'b0);
    settle();

    // New bound without init: listed pages stay, address checks move.
    write_low_page(16'd65528);
    run_random(300, 1'b0, 1'b0);
    settle();

    write_low_page(16'($urandom_range(65472, 65530)));
    send(r);
    run_random(700, 1'b0, 1'b1);
    settle();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rpa_pkg.sv
rtl/rpa_outbuf.sv
rtl/rpa_core.sv
rtl/refcounted_page_allocator.sv
tb/tb.sv
